// ===== sv/sakf_pkg.sv =====
// ============================================================================
// sakf_pkg: shared types and constants of the scalar AR(1) Kalman filter
// Field widths, register indexes, multiplier operand selects, controller
// states and the command/status bundles between controller and datapath.
// ============================================================================
package sakf_pkg;

    // Default data path format: Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // AR coefficient is unsigned Q0.16
    localparam int COEF_BITS = 16;

    // Fixed field widths on the ports
    localparam int FIELD_WIDTH    = 32;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int IN_TDATA_WIDTH  = 2 * FIELD_WIDTH;
    localparam int OUT_TDATA_WIDTH = 4 * FIELD_WIDTH;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_AR_COEF    = 3'd0,
        REG_PROC_NOISE = 3'd1,
        REG_OBS_NOISE  = 3'd2,
        REG_BASELINE   = 3'd3,
        REG_INIT_VAR   = 3'd4
    } cfg_index_t;

    // Operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,   // hold the product register
        MUL_MG,     // state mean * coefficient
        MUL_GG,     // coefficient * coefficient
        MUL_PG2,    // state variance * squared coefficient
        MUL_EK,     // innovation * gain
        MUL_OK      // observation noise * gain
    } mul_op_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_MG,
        ST_MUL_GG,
        ST_MUL_PG2,
        ST_TAKE_R,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_MUL_EK,
        ST_MUL_OK,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_in;    // capture input sample, reload on start flag
        mul_op_t mul_op;     // multiplier operand select
        logic    take_a;     // register predicted mean
        logic    take_r;     // register predicted variance and innovation
        logic    div_init;   // set up gain division
        logic    div_step;   // one quotient bit
        logic    div_first;  // first quotient bit (no shift)
        logic    take_m;     // register filtered mean
        logic    take_p;     // register filtered variance, update state, emit
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;      // output register can take a new result
    } dp_status_t;

endpackage

// ===== sv/scalar_ar1_kalman_filter_top.sv =====
// ============================================================================
// scalar_ar1_kalman_filter_top: scalar AR(1) Kalman filter, forward pass
// Predicts a = g*m + drive, R = g*g*P + q, forms K = R/(R + r_obs) and
// updates m = a + K*(y - baseline - a), P = r_obs*K in saturating fixed point.
//
//   channel   direction  handshake            payload
//   s_axis    in         tvalid/tready        tdata {drive, observation}, tuser start
//   m_axis    out        tvalid/tready        tdata {P, m, R, a}, tuser saturated
//   cfg       in         cfg_wr_en            cfg_addr, cfg_wr_data
//
// Between its transfer and the next input transfer, a sample passes through the
// accept step, three shared multiplies, the setup steps, the restoring gain
// divider (one quotient bit per cycle, FRAC_BITS + 1 bits, Q16.16 by default),
// two more shared multiplies and the write-back step.
// The result waits in an output register, so the next sample is taken while
// it is still unread; a stalled output holds the sequencer only at its last step.
// Reset clears the configuration registers and the filter state to zero.
// ============================================================================
module scalar_ar1_kalman_filter_top #(
    parameter int DATA_WIDTH = sakf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sakf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [sakf_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [sakf_pkg::CFG_DATA_WIDTH-1:0]   cfg_wr_data,
    // input samples
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [sakf_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,  // observation, drive_amplitude
    input  logic                                  s_axis_tuser,  // start_of_series
    // filter results
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [sakf_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,  // predicted_mean,
                                                                 // predicted_variance,
                                                                 // filtered_mean,
                                                                 // filtered_variance
    output logic                                  m_axis_tuser   // saturated
);

    sakf_pkg::ctrl_cmd_t  cmd;
    sakf_pkg::dp_status_t status;

    // Sequencer
    sakf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Arithmetic and storage
    sakf_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ===== sv/sakf_ctrl.sv =====
// ============================================================================
// sakf_ctrl: sequencer of the scalar AR(1) Kalman filter
// Steps one sample through prediction, gain division and update, issuing
// one datapath command per cycle while it is not waiting for an input sample or a free output register.
// ============================================================================
module sakf_ctrl #(
    parameter int FRAC_BITS = sakf_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  sakf_pkg::dp_status_t  status,
    output sakf_pkg::ctrl_cmd_t   cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    sakf_pkg::state_t state_reg;
    sakf_pkg::state_t state_next;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0] div_cnt_next;

    // State and quotient bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sakf_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.mul_op    = sakf_pkg::MUL_NONE;

        case (state_reg)
            sakf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sakf_pkg::ST_MUL_MG;
                end
            end
            sakf_pkg::ST_MUL_MG:
            begin
                cmd.mul_op = sakf_pkg::MUL_MG;
                state_next = sakf_pkg::ST_MUL_GG;
            end
            sakf_pkg::ST_MUL_GG:
            begin
                cmd.take_a = 1'b1;
                cmd.mul_op = sakf_pkg::MUL_GG;
                state_next = sakf_pkg::ST_MUL_PG2;
            end
            sakf_pkg::ST_MUL_PG2:
            begin
                cmd.mul_op = sakf_pkg::MUL_PG2;
                state_next = sakf_pkg::ST_TAKE_R;
            end
            sakf_pkg::ST_TAKE_R:
            begin
                cmd.take_r = 1'b1;
                state_next = sakf_pkg::ST_DIV_INIT;
            end
            sakf_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = sakf_pkg::ST_DIVIDE;
            end
            sakf_pkg::ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (div_cnt_reg == '0);
                div_cnt_next  = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = sakf_pkg::ST_MUL_EK;
                end
            end
            sakf_pkg::ST_MUL_EK:
            begin
                cmd.mul_op = sakf_pkg::MUL_EK;
                state_next = sakf_pkg::ST_MUL_OK;
            end
            sakf_pkg::ST_MUL_OK:
            begin
                cmd.take_m = 1'b1;
                cmd.mul_op = sakf_pkg::MUL_OK;
                state_next = sakf_pkg::ST_FINISH;
            end
            sakf_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.take_p = 1'b1;
                    state_next = sakf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sakf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sakf_datapath.sv =====
// ============================================================================
// sakf_datapath: arithmetic of the scalar AR(1) Kalman filter
// Configuration registers, filter state, one shared registered multiplier,
// a restoring gain divider, saturation logic and the output register.
// ============================================================================
module sakf_datapath #(
    parameter int DATA_WIDTH = sakf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sakf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [sakf_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [sakf_pkg::CFG_DATA_WIDTH-1:0]   cfg_wr_data,
    // input payload
    input  logic [sakf_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
    input  logic                                  s_axis_tuser,
    // output channel
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [sakf_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
    output logic                                  m_axis_tuser,
    // controller link
    input  sakf_pkg::ctrl_cmd_t                   cmd,
    output sakf_pkg::dp_status_t                  status
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = sakf_pkg::COEF_BITS;
    localparam int FW  = sakf_pkg::FIELD_WIDTH;
    localparam int XW  = (W > FW) ? W : FW;               // wide view of W-bit values
    localparam int EW  = XW + 2;                          // innovation, multiplier A
    localparam int KW  = F + 1;                           // gain in [0, 1]
    localparam int BW  = ((CW > KW) ? CW : KW) + 1;       // multiplier B, signed
    localparam int PW  = EW + BW;                         // product
    localparam int SW  = PW + 1;                          // sums before saturation
    localparam int DW  = XW + 1;                          // gain denominator
    localparam int RW  = XW + 2;                          // divider remainder

    localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] UMAX = {{(SW-W){1'b0}}, {W{1'b1}}};
    localparam logic [XW-1:0]        UMAX_X = XW'({W{1'b1}});

    // Configuration registers
    logic [CW-1:0]        ar_coef_reg;
    logic [FW-1:0]        proc_noise_reg;
    logic [FW-1:0]        obs_noise_reg;
    logic signed [FW-1:0] baseline_reg;
    logic [FW-1:0]        init_var_reg;

    // Filter state
    logic signed [W-1:0]  mean_state_reg;
    logic [W-1:0]         var_state_reg;

    // Working registers
    logic signed [FW-1:0] obs_reg;
    logic [FW-1:0]        drive_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [W-1:0]  a_reg;
    logic [W-1:0]         r_reg;
    logic signed [EW-1:0] e_reg;
    logic signed [W-1:0]  m_reg;
    logic [DW-1:0]        den_reg;
    logic                 den_zero_reg;
    logic [RW-1:0]        rem_reg;
    logic [KW-1:0]        q_reg;
    logic                 flag_reg;

    // Output register
    logic                 out_valid_reg;
    logic [sakf_pkg::OUT_TDATA_WIDTH-1:0] out_data_reg;
    logic                 out_sat_reg;

    // Combinational values
    logic signed [EW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [XW-1:0]        iv_x;
    logic                 iv_ovf;
    logic [W-1:0]         iv_sat;
    logic signed [SW-1:0] a_sum;
    logic                 a_ovf;
    logic signed [W-1:0]  a_sat;
    logic signed [SW-1:0] r_sum;
    logic                 r_ovf;
    logic [W-1:0]         r_sat;
    logic signed [EW-1:0] e_val;
    logic [DW-1:0]        den_val;
    logic [RW-1:0]        trial;
    logic                 trial_ge;
    logic [KW-1:0]        gain;
    logic signed [SW-1:0] m_sum;
    logic                 m_ovf;
    logic signed [W-1:0]  m_sat;
    logic signed [SW-1:0] p_sum;
    logic                 p_ovf;
    logic [W-1:0]         p_sat;
    logic signed [XW-1:0] a_x;
    logic [XW-1:0]        r_x;
    logic signed [XW-1:0] m_x;
    logic [XW-1:0]        p_x;

    // Gain is zero when the denominator is zero
    assign gain = den_zero_reg ? '0 : q_reg;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            sakf_pkg::MUL_MG:
            begin
                mul_a = EW'(mean_state_reg);
                mul_b = BW'(ar_coef_reg);
            end
            sakf_pkg::MUL_GG:
            begin
                mul_a = EW'(ar_coef_reg);
                mul_b = BW'(ar_coef_reg);
            end
            sakf_pkg::MUL_PG2:
            begin
                mul_a = EW'(var_state_reg);
                mul_b = BW'(prod_reg[2*CW-1:CW]);
            end
            sakf_pkg::MUL_EK:
            begin
                mul_a = e_reg;
                mul_b = BW'(gain);
            end
            sakf_pkg::MUL_OK:
            begin
                mul_a = EW'(obs_noise_reg);
                mul_b = BW'(gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Initial variance clipped to the data range
    assign iv_x   = XW'(init_var_reg);
    assign iv_ovf = iv_x > UMAX_X;
    assign iv_sat = iv_ovf ? {W{1'b1}} : iv_x[W-1:0];

    // Predicted mean: floor(m * g) + drive
    assign a_sum = SW'(prod_reg >>> CW) + SW'($signed({1'b0, drive_reg}));
    always_comb
    begin
        a_ovf = 1'b1;
        if (a_sum > SMAX)
        begin
            a_sat = SMAX[W-1:0];
        end
        else if (a_sum < SMIN)
        begin
            a_sat = SMIN[W-1:0];
        end
        else
        begin
            a_sat = a_sum[W-1:0];
            a_ovf = 1'b0;
        end
    end

    // Predicted variance: floor(g2 * P) + process noise
    assign r_sum = SW'(prod_reg >>> CW) + SW'($signed({1'b0, proc_noise_reg}));
    assign r_ovf = r_sum > UMAX;
    assign r_sat = r_ovf ? {W{1'b1}} : r_sum[W-1:0];

    // Innovation at full precision
    assign e_val = EW'(obs_reg) - EW'(baseline_reg) - EW'(a_reg);

    // Gain denominator and one restoring divider step
    assign den_val  = DW'(r_reg) + DW'(obs_noise_reg);
    assign trial    = cmd.div_first ? rem_reg : (rem_reg << 1);
    assign trial_ge = trial >= RW'(den_reg);

    // Filtered mean: a + floor(e * K)
    assign m_sum = SW'(a_reg) + SW'(prod_reg >>> F);
    always_comb
    begin
        m_ovf = 1'b1;
        if (m_sum > SMAX)
        begin
            m_sat = SMAX[W-1:0];
        end
        else if (m_sum < SMIN)
        begin
            m_sat = SMIN[W-1:0];
        end
        else
        begin
            m_sat = m_sum[W-1:0];
            m_ovf = 1'b0;
        end
    end

    // Filtered variance: floor(obs noise * K)
    assign p_sum = SW'(prod_reg >>> F);
    assign p_ovf = p_sum > UMAX;
    assign p_sat = p_ovf ? {W{1'b1}} : p_sum[W-1:0];

    // Extend results, then keep the low field bits
    assign a_x = XW'(a_reg);
    assign r_x = XW'(r_reg);
    assign m_x = XW'(m_reg);
    assign p_x = XW'(p_sat);

    assign status.out_free = !out_valid_reg || m_axis_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_coef_reg    <= '0;
            proc_noise_reg <= '0;
            obs_noise_reg  <= '0;
            baseline_reg   <= '0;
            init_var_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                sakf_pkg::REG_AR_COEF:    ar_coef_reg    <= cfg_wr_data[CW-1:0];
                sakf_pkg::REG_PROC_NOISE: proc_noise_reg <= cfg_wr_data;
                sakf_pkg::REG_OBS_NOISE:  obs_noise_reg  <= cfg_wr_data;
                sakf_pkg::REG_BASELINE:   baseline_reg   <= $signed(cfg_wr_data);
                sakf_pkg::REG_INIT_VAR:   init_var_reg   <= cfg_wr_data;
                default:                  ;
            endcase
        end
    end

    // Filter state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_state_reg <= '0;
            var_state_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in && s_axis_tuser)
            begin
                mean_state_reg <= '0;
                var_state_reg  <= iv_sat;
            end
            else if (cmd.take_p)
            begin
                mean_state_reg <= m_reg;
                var_state_reg  <= p_sat;
            end

            if (cmd.take_p)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            obs_reg   <= $signed(s_axis_tdata[FW-1:0]);
            drive_reg <= s_axis_tdata[2*FW-1:FW];
            flag_reg  <= s_axis_tuser && iv_ovf;
        end

        if (cmd.mul_op != sakf_pkg::MUL_NONE)
        begin
            prod_reg <= prod;
        end

        if (cmd.take_a)
        begin
            a_reg    <= a_sat;
            flag_reg <= flag_reg | a_ovf;
        end

        if (cmd.take_r)
        begin
            r_reg    <= r_sat;
            e_reg    <= e_val;
            flag_reg <= flag_reg | r_ovf;
        end

        if (cmd.div_init)
        begin
            den_reg      <= den_val;
            den_zero_reg <= (den_val == '0);
            rem_reg      <= RW'(r_reg);
            q_reg        <= '0;
        end

        // advance the quotient by one bit
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? (trial - RW'(den_reg)) : trial;
            q_reg   <= {q_reg[KW-2:0], trial_ge};
        end

        if (cmd.take_m)
        begin
            m_reg    <= m_sat;
            flag_reg <= flag_reg | m_ovf;
        end

        if (cmd.take_p)
        begin
            out_data_reg <= {p_x[FW-1:0], m_x[FW-1:0], r_x[FW-1:0], a_x[FW-1:0]};
            out_sat_reg  <= flag_reg | p_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
